// ===== sv/ssbg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbg_pkg
// Shared types and constants of the sprite sort and batch grouping block.
// ----------------------------------------------------------------------------
package ssbg_pkg;

  localparam int unsigned VERTS = 6;

  typedef enum logic [1:0] {
    MODE_DEPTH_UP   = 2'd0,
    MODE_DEPTH_DOWN = 2'd1,
    MODE_TEXTURE    = 2'd2,
    MODE_ARRIVAL    = 2'd3
  } sort_mode_t;

  localparam logic [0:0] REG_SORT_MODE = 1'b0;

  // Front-to-back queue entry: one classified sprite.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tex;
    logic        last;
    logic        keep;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'd0,
    ST_SORT = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // Sort key: larger sorts later.
  function automatic logic [31:0] make_key(input logic [31:0] depth,
                                            input logic [15:0] tex,
                                            input sort_mode_t mode);
    logic [31:0] d;
    d = depth ^ 32'h8000_0000;
    unique case (mode)
      MODE_DEPTH_UP:   make_key = d;
      MODE_DEPTH_DOWN: make_key = ~d;
      MODE_TEXTURE:    make_key = {16'd0, tex};
      default:         make_key = 32'd0;
    endcase
  endfunction

endpackage

// ===== sv/sprite_sort_and_batch_grouping_top.sv =====
// ----------------------------------------------------------------------------
// sprite_sort_and_batch_grouping_top
// Stable sprite sort with texture batch grouping.
// ----------------------------------------------------------------------------
// Sprites are taken one per cycle, unless the input queue is full, into an
// insertion-sort cell array (one compare per cell). The item flagged last
// closes the set; after a settle state the sorted sprites leave one per cycle
// from the head cell while the output is not stalled, and new sprites wait in
// a two-entry queue. Sprites beyond MAX_SPRITES are dropped.
module sprite_sort_and_batch_grouping_top #(
  parameter int unsigned MAX_SPRITES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_depth_key,
  input  logic [15:0] in_texture_id,
  input  logic        in_last_sprite,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_sprite_index,
  output logic [15:0] out_sprite_texture,
  output logic [8:0]  out_vertex_offset,
  output logic        out_batch_start,
  output logic        out_batch_end,
  output logic [8:0]  out_batch_vertex_count,
  output logic        out_last_result
);
  import ssbg_pkg::*;

  sort_mode_t mode_r;
  logic       q_valid, q_pop;
  q_item_t    q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SORT_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXTURE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_SORT_MODE) begin
      mode_r <= sort_mode_t'(cfg_pwdata[1:0]);
    end
  end

  ssbg_front u_front (
    .clk, .rst_n, .mode(mode_r),
    .in_valid, .in_stall,
    .in_depth_key(in_depth_key), .in_texture_id, .in_last_sprite,
    .q_valid, .q_pop, .q_data
  );

  ssbg_back #(.N(MAX_SPRITES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_sprite_index, .out_sprite_texture,
    .out_vertex_offset, .out_batch_start, .out_batch_end,
    .out_batch_vertex_count, .out_last_result
  );

endmodule

// ===== sv/ssbg_front.sv =====
// ----------------------------------------------------------------------------
// ssbg_front
// Takes sprites, computes their sort key, and pushes them into a small queue.
// ----------------------------------------------------------------------------
module ssbg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssbg_pkg::sort_mode_t  mode,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_depth_key,
  input  logic [15:0]           in_texture_id,
  input  logic                  in_last_sprite,
  output logic                  q_valid,
  input  logic                  q_pop,
  output ssbg_pkg::q_item_t     q_data
);
  import ssbg_pkg::*;

  q_item_t    q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;
  q_item_t    item;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  always_comb begin
    item.key  = make_key(in_depth_key, in_texture_id, mode);
    item.tex  = in_texture_id;
    item.last = in_last_sprite;
    item.keep = 1'b1;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) q_r[wr_r] <= item;
  end

endmodule

// ===== sv/ssbg_back.sv =====
// ----------------------------------------------------------------------------
// ssbg_back
// Insertion-sort array of cells that takes one sprite a cycle, then a
// settle pass and a shift-out that forms the draw batches.
// ----------------------------------------------------------------------------
module ssbg_back #(
  parameter int unsigned N = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  ssbg_pkg::q_item_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_sprite_index,
  output logic [15:0]       out_sprite_texture,
  output logic [8:0]        out_vertex_offset,
  output logic              out_batch_start,
  output logic              out_batch_end,
  output logic [8:0]        out_batch_vertex_count,
  output logic              out_last_result
);
  import ssbg_pkg::*;

  localparam int unsigned CW = $clog2(N + 1);

  // Cells: sorted ascending from cell 0; occupied cells form a prefix.
  logic [31:0] key_r [N];
  logic [15:0] tex_r [N];
  logic [5:0]  idx_r [N];
  logic [N-1:0] occ_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  state_t st_r, st_nxt;

  logic [8:0] rank_r, rank_nxt;
  logic [8:0] run_r, run_nxt;
  logic [15:0] prev_tex_r, prev_tex_nxt;
  logic       first_r, first_nxt;
  logic       emit_go, take;
  logic [N-1:0] gt;
  logic [N-1:0] ins;
  logic       out_free;
  logic       bstart_c, out_batch_end_c;
  logic [8:0] run_cur;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (st_r == ST_LOAD) && q_valid;
  assign take     = q_pop && (cnt_r < CW'(N));

  // Cell i gives way to the new sprite if its key is strictly larger than the new
  // one (stable: equal keys stay ahead) or it is free.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = !occ_r[i] || (key_r[i] > q_data.key);
    end
  end

  // The insertion point is the cell that moves while its neighbor below does not.
  assign ins = gt & ~{gt[N-2:0], 1'b0};

  // Emission pops cell 0 and shifts the array down.
  assign emit_go = (st_r == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (take) begin
        if (ins[i]) begin
          key_r[i] <= q_data.key;
          tex_r[i] <= q_data.tex;
          idx_r[i] <= 6'(cnt_r);
        end else if (gt[i]) begin
          key_r[i] <= key_r[(i == 0) ? 0 : i - 1];
          tex_r[i] <= tex_r[(i == 0) ? 0 : i - 1];
          idx_r[i] <= idx_r[(i == 0) ? 0 : i - 1];
        end
      end else if (emit_go && i < N - 1) begin
        key_r[i] <= key_r[(i < N - 1) ? i + 1 : i];
        tex_r[i] <= tex_r[(i < N - 1) ? i + 1 : i];
        idx_r[i] <= idx_r[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (take) begin
      occ_r <= {occ_r[N-2:0], 1'b1};
    end else if (emit_go) begin
      occ_r <= {1'b0, occ_r[N-1:1]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD: if (q_pop && q_data.last) st_nxt = ST_SORT;
      ST_SORT: st_nxt = ST_EMIT;
      ST_EMIT: if (emit_go && !occ_r[1]) st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    rank_nxt     = rank_r;
    run_nxt      = run_r;
    prev_tex_nxt = prev_tex_r;
    first_nxt    = first_r;
    if (take) cnt_nxt = cnt_r + 1'b1;
    if (st_r == ST_SORT) begin
      rank_nxt  = 9'd0;
      run_nxt   = 9'd0;
      first_nxt = 1'b1;
    end
    if (emit_go) begin
      rank_nxt     = rank_r + 9'(VERTS);
      prev_tex_nxt = tex_r[0];
      first_nxt    = 1'b0;
      run_nxt      = out_batch_end_c ? 9'd0 : run_cur;
      if (!occ_r[1]) cnt_nxt = '0;
    end
  end

  always_comb begin
    bstart_c        = first_r || (prev_tex_r != tex_r[0]);
    run_cur         = (bstart_c ? 9'd0 : run_r) + 9'(VERTS);
    out_batch_end_c = !occ_r[1] || (tex_r[1] != tex_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_LOAD;
      cnt_r     <= '0;
      first_r   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      if (emit_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    rank_r     <= rank_nxt;
    run_r      <= run_nxt;
    prev_tex_r <= prev_tex_nxt;
    if (emit_go) begin
      out_sprite_index       <= idx_r[0];
      out_sprite_texture     <= tex_r[0];
      out_vertex_offset      <= rank_r;
      out_batch_start        <= bstart_c;
      out_batch_end          <= out_batch_end_c;
      out_batch_vertex_count <= out_batch_end_c ? run_cur : 9'd0;
      out_last_result        <= !occ_r[1];
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sprite sort and batch grouping block.
// ----------------------------------------------------------------------------
// Sprite sets are sent through the input channel. Each closing sprite makes
// the testbench sort its own copy of the set and queue the sorted sprites with
// their batch flags. A checker compares every result with the oldest queued
// sprite. Sort modes are changed over the APB port between sets.
module tb;
  import ssbg_pkg::*;

  localparam int MAXN = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] tex;
    logic [8:0]  voff;
    logic        bstart;
    logic        bend;
    logic [8:0]  bcount;
    logic        last;
  } sorted_sprite_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  logic        in_valid, in_stall;
  logic signed [31:0] in_depth_key;
  logic [15:0] in_texture_id;
  logic        in_last_sprite;
  logic        out_valid, out_stall;
  logic [5:0]  out_sprite_index;
  logic [15:0] out_sprite_texture;
  logic [8:0]  out_vertex_offset;
  logic        out_batch_start, out_batch_end;
  logic [8:0]  out_batch_vertex_count;
  logic        out_last_result;

  sprite_sort_and_batch_grouping_top DUT (.*);

  // Testbench copy of the block state.
  logic [31:0]    set_depth [MAXN];
  logic [15:0]    set_tex [MAXN];
  int             set_size;
  sort_mode_t     mode;
  sorted_sprite_t draw_queue[$];

  int errors, sprites_sent, results_seen, sets_closed, idle_cycles;
  int send_idle_pct, recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] order_key(logic [31:0] d, logic [15:0] t);
    case (mode)
      MODE_DEPTH_UP:   return d ^ 32'h8000_0000;
      MODE_DEPTH_DOWN: return ~(d ^ 32'h8000_0000);
      MODE_TEXTURE:    return {16'd0, t};
      default:         return 32'd0;
    endcase
  endfunction

  // Model of one accepted sprite; a closing sprite queues the sorted set.
  task automatic take_sprite(logic [31:0] d, logic [15:0] t, logic last);
    int order[MAXN];
    int i, j, cur, first;
    sorted_sprite_t s;
    if (set_size < MAXN) begin
      set_depth[set_size] = d;
      set_tex[set_size] = t;
      set_size++;
    end
    if (!last) return;
    for (i = 0; i < set_size; i++) begin
      cur = i;
      j = i;
      while (j > 0 && order_key(set_depth[order[j-1]], set_tex[order[j-1]]) >
                      order_key(set_depth[cur], set_tex[cur])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    first = 0;
    for (i = 0; i < set_size; i++) begin
      s.idx = 6'(order[i]);
      s.tex = set_tex[order[i]];
      s.voff = 9'(i * VERTS);
      s.bstart = (i == 0) || (set_tex[order[i-1]] != s.tex);
      s.bend = (i + 1 == set_size) || (set_tex[order[i+1]] != s.tex);
      if (s.bstart) first = i;
      s.bcount = s.bend ? 9'((i - first + 1) * VERTS) : 9'd0;
      s.last = (i + 1 == set_size);
      draw_queue.push_back(s);
    end
    set_size = 0;
    sets_closed++;
  endtask

  // Returns at the rising edge that accepts the item; valid stays high so the
  // next item can follow without a gap.
  task automatic send_sprite(logic [31:0] d, logic [15:0] t, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_depth_key <= d;
    in_texture_id <= t;
    in_last_sprite <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_sprite(d, t, last);
    sprites_sent++;
  endtask

  task automatic write_mode(sort_mode_t m);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(REG_SORT_MODE) * 3'd4;
    cfg_pwdata <= 32'(m);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mode = m;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (draw_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random set; textures are drawn from 0 to tex_span, so a small span makes batches form often.
  task automatic send_set(int n, int tex_span);
    int k;
    logic [31:0] d;
    for (k = 0; k < n; k++) begin
      d = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) - 32'd3 : $urandom;
      send_sprite(d, 16'($urandom_range(tex_span)), k == n - 1);
    end
  endtask

  task automatic test_directed;
    write_mode(MODE_DEPTH_UP);
    send_sprite(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_sprite(32'h8000_0000, 16'h0000, 1'b0);
    send_sprite(32'h0001_0000, 16'hFFFF, 1'b0);
    send_sprite(32'h0001_0000, 16'h0000, 1'b0);
    send_sprite(32'hFFFF_FFFF, 16'h5A5A, 1'b1);
    send_sprite(32'h1234_5678, 16'hA5A5, 1'b1);   // set of one sprite
    drain;
    write_mode(MODE_DEPTH_DOWN);
    send_set(6, 2);
    drain;
    write_mode(MODE_ARRIVAL);
    send_set(5, 1);
    drain;
    write_mode(MODE_TEXTURE);
    send_set(6, 3);
  endtask

  // Overfilled set: sprites past the store size are dropped.
  task automatic test_full_store;
    drain;
    write_mode(MODE_DEPTH_DOWN);
    send_set(MAXN + 3, 4);
  endtask

  task automatic test_random;
    int budget, n;
    sort_mode_t m;
    budget = 80;
    while (budget > 0) begin
      drain;
      m = sort_mode_t'($urandom_range(3));
      write_mode(m);
      n = $urandom_range(1, 12);
      send_set(n, ($urandom_range(1) != 0) ? 3 : 65535);
      budget -= n;
      if (budget < 54 && send_idle_pct == 19) begin
        send_idle_pct = 82;
        recv_idle_pct = 19;
      end else if (budget < 27 && send_idle_pct == 82) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
  endtask

  // Receiver stall and result checking.
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    sorted_sprite_t e, a;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      a = '{out_sprite_index, out_sprite_texture, out_vertex_offset,
            out_batch_start, out_batch_end, out_batch_vertex_count,
            out_last_result};
      if (draw_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, a);
      end else begin
        e = draw_queue.pop_front();
        if (e.idx != a.idx || e.tex != a.tex || e.voff != a.voff ||
            e.bstart != a.bstart || e.bend != a.bend ||
            e.bcount != a.bcount || e.last != a.last) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, e, a);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0; sprites_sent = 0; results_seen = 0; sets_closed = 0;
    idle_cycles = 0; set_size = 0; mode = MODE_TEXTURE;
    send_idle_pct = 19; recv_idle_pct = 82;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_valid = 1'b0; in_depth_key = '0; in_texture_id = '0; in_last_sprite = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed;
    test_full_store;
    test_random;
    drain;
    repeat (20) @(negedge clk);
    $display("Covered %0d sprites in %0d sets, all four sort modes, full store.",
             sprites_sent, sets_closed);
    $display("Checked %0d results, %0d errors.", results_seen, errors);
    if (errors == 0 && draw_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/ssbg_pkg.sv
sv/ssbg_front.sv
sv/ssbg_back.sv
sv/sprite_sort_and_batch_grouping_top.sv
sim/tb.sv
